/* sv/nps_pkg.sv */
// Shared types, widths and codes for the near pair search block.
package nps_pkg;

    localparam int POS_W      = 24;
    localparam int RAD_W      = 16;
    localparam int GRP_W      = 3;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int MASK_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam int SQ_W       = 2 * POS_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int REACH_W    = RAD_W + 3;
    localparam int REACH_SQ_W = 2 * REACH_W;

    localparam int MAX_OBJECTS_DEF = 64;
    localparam int GROUP_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MASK   = 1'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SCAN,
        OP_EMPTY
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MREAD,
        ST_MLATCH,
        ST_WALK,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [RAD_W-1:0] radius;
        logic [GRP_W-1:0] group;
    } t_rec;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] final_j;
        t_rec             rec;
    } t_job;

endpackage

/* sv/nps_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module nps_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/nps_front.sv */
// Front end: accepts items and classifies them into jobs for the queue.
module nps_front #(
    parameter int MAX_OBJECTS = nps_pkg::MAX_OBJECTS_DEF
) (
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic [nps_pkg::IDX_W-1:0]   i_index,
    input  logic [nps_pkg::POS_W-1:0]   i_pos_x,
    input  logic [nps_pkg::POS_W-1:0]   i_pos_y,
    input  logic [nps_pkg::POS_W-1:0]   i_pos_z,
    input  logic [nps_pkg::RAD_W-1:0]   i_radius,
    input  logic [nps_pkg::GRP_W-1:0]   i_group,
    input  logic [nps_pkg::CNT_W-1:0]   i_object_count,
    input  logic                        i_q_full,
    output logic                        o_push,
    output nps_pkg::t_job               o_job
);

    localparam logic [nps_pkg::CNT_W-1:0] MaxCnt = nps_pkg::CNT_W'(MAX_OBJECTS);

    logic [nps_pkg::CNT_W-1:0] cnt;
    logic [nps_pkg::CNT_W-1:0] row;
    logic [nps_pkg::CNT_W-1:0] last_j;
    logic                      in_range;
    logic                      row_empty;

    always_comb begin
        cnt       = (i_object_count > MaxCnt) ? MaxCnt : i_object_count;
        row       = {1'b0, i_index};
        in_range  = row < MaxCnt;
        // A row has partners only if at least one slot above it is counted.
        row_empty = !in_range || ((row + 1'b1) >= cnt);
        last_j    = cnt - 1'b1;
    end

    always_comb begin
        o_job.index      = i_index;
        o_job.final_j    = last_j[nps_pkg::IDX_W-1:0];
        o_job.rec.x      = i_pos_x;
        o_job.rec.y      = i_pos_y;
        o_job.rec.z      = i_pos_z;
        o_job.rec.radius = i_radius;
        o_job.rec.group  = i_group;
        if (i_kind == nps_pkg::KIND_LOAD) begin
            o_job.op = nps_pkg::OP_LOAD;
        end else if (row_empty) begin
            o_job.op = nps_pkg::OP_EMPTY;
        end else begin
            o_job.op = nps_pkg::OP_SCAN;
        end
    end

    // Loads to slots beyond the store are taken and dropped.
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full
                        && !(i_kind == nps_pkg::KIND_LOAD && !in_range);

endmodule

/* sv/nps_queue.sv */
// Short job queue between the front end and the back end.
module nps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nps_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output nps_pkg::t_job o_job
);

    localparam int Depth = nps_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    nps_pkg::t_job   r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* sv/nps_back.sv */
// Back end: object store, pipelined distance test and result register.
module nps_back #(
    parameter int MAX_OBJECTS = nps_pkg::MAX_OBJECTS_DEF,
    parameter int GROUP_COUNT = nps_pkg::GROUP_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    input  nps_pkg::t_job                      i_job,
    output logic                               o_pop,
    input  logic [nps_pkg::MASK_W-1:0]         i_group_pair_mask,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [nps_pkg::IDX_W-1:0]          o_master_index,
    output logic [nps_pkg::IDX_W-1:0]          o_partner_index,
    output logic                               o_found,
    output logic                               o_last
);

    localparam int AddrW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int RecW  = $bits(nps_pkg::t_rec);

    nps_pkg::t_state r_state;
    nps_pkg::t_state n_state;

    logic [nps_pkg::IDX_W-1:0] r_row;
    logic [nps_pkg::IDX_W-1:0] r_final;
    logic [nps_pkg::IDX_W-1:0] r_j;
    nps_pkg::t_rec             r_master;

    logic                      ram_we;
    logic                      ram_re;
    logic [AddrW-1:0]          ram_raddr;
    logic [RecW-1:0]           ram_rdata;
    nps_pkg::t_rec             partner;

    logic                      adv;
    logic                      issue;
    logic                      emit_hit;
    logic                      emit_flush;

    // Stage 1 travels with the registered store read.
    logic                      r_s1_v;
    logic                      r_s1_fin;
    logic [nps_pkg::IDX_W-1:0] r_s1_j;

    logic [nps_pkg::POS_W-1:0]   s1_dx;
    logic [nps_pkg::POS_W-1:0]   s1_dy;
    logic [nps_pkg::POS_W-1:0]   s1_dz;
    logic [nps_pkg::REACH_W-1:0] s1_reach;
    logic                        s1_grp_ok;
    logic [nps_pkg::RAD_W:0]     rad_sum;
    logic [nps_pkg::IDX_W-1:0]   mask_idx;

    logic                        r_s2_v;
    logic                        r_s2_fin;
    logic [nps_pkg::IDX_W-1:0]   r_s2_j;
    logic [nps_pkg::POS_W-1:0]   r_s2_dx;
    logic [nps_pkg::POS_W-1:0]   r_s2_dy;
    logic [nps_pkg::POS_W-1:0]   r_s2_dz;
    logic [nps_pkg::REACH_W-1:0] r_s2_reach;
    logic                        r_s2_grp_ok;

    logic                           r_s3_v;
    logic                           r_s3_fin;
    logic [nps_pkg::IDX_W-1:0]      r_s3_j;
    logic [nps_pkg::SQ_W-1:0]       r_s3_sqx;
    logic [nps_pkg::SQ_W-1:0]       r_s3_sqy;
    logic [nps_pkg::SQ_W-1:0]       r_s3_sqz;
    logic [nps_pkg::REACH_SQ_W-1:0] r_s3_reach_sq;
    logic                           r_s3_grp_ok;
    logic [nps_pkg::SUM_W-1:0]      s3_sum;
    logic                           s3_hit;

    logic                      r_pend_v;
    logic [nps_pkg::IDX_W-1:0] r_pend_j;

    logic                      r_out_valid;
    logic [nps_pkg::IDX_W-1:0] r_out_master;
    logic [nps_pkg::IDX_W-1:0] r_out_partner;
    logic                      r_out_found;
    logic                      r_out_last;

    function automatic logic [nps_pkg::POS_W-1:0] abs_diff(
        input logic [nps_pkg::POS_W-1:0] a,
        input logic [nps_pkg::POS_W-1:0] b
    );
        logic [nps_pkg::POS_W:0] d;
        logic [nps_pkg::POS_W:0] m;
        d = {a[nps_pkg::POS_W-1], a} - {b[nps_pkg::POS_W-1], b};
        m = d[nps_pkg::POS_W] ? (~d + 1'b1) : d;
        return m[nps_pkg::POS_W-1:0];
    endfunction

    nps_ram #(
        .WIDTH (RecW),
        .DEPTH (MAX_OBJECTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_job.index[AddrW-1:0]),
        .i_wdata (i_job.rec),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign partner = nps_pkg::t_rec'(ram_rdata);

    // The whole walk pipeline moves only when the result register can take a word.
    assign adv = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            nps_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    case (i_job.op)
                        nps_pkg::OP_SCAN:  n_state = nps_pkg::ST_MREAD;
                        nps_pkg::OP_EMPTY: n_state = nps_pkg::ST_FLUSH;
                        default:           n_state = nps_pkg::ST_IDLE;
                    endcase
                end
            end
            nps_pkg::ST_MREAD:  n_state = nps_pkg::ST_MLATCH;
            nps_pkg::ST_MLATCH: n_state = nps_pkg::ST_WALK;
            nps_pkg::ST_WALK: begin
                if (adv && r_j == r_final) begin
                    n_state = nps_pkg::ST_DRAIN;
                end
            end
            nps_pkg::ST_DRAIN: begin
                if (adv && r_s3_v && r_s3_fin) begin
                    n_state = nps_pkg::ST_FLUSH;
                end
            end
            nps_pkg::ST_FLUSH: begin
                if (adv) begin
                    n_state = nps_pkg::ST_IDLE;
                end
            end
            default: n_state = nps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = (r_state == nps_pkg::ST_IDLE) && !i_q_empty;
        ram_we     = o_pop && (i_job.op == nps_pkg::OP_LOAD);
        issue      = (r_state == nps_pkg::ST_WALK) && adv;
        ram_re     = (r_state == nps_pkg::ST_MREAD) || issue;
        ram_raddr  = (r_state == nps_pkg::ST_MREAD) ? r_row[AddrW-1:0] : r_j[AddrW-1:0];
        emit_flush = (r_state == nps_pkg::ST_FLUSH) && adv;
    end

    always_comb begin
        s1_dx     = abs_diff(r_master.x, partner.x);
        s1_dy     = abs_diff(r_master.y, partner.y);
        s1_dz     = abs_diff(r_master.z, partner.z);
        rad_sum   = {1'b0, r_master.radius} + {1'b0, partner.radius};
        s1_reach  = {2'b00, rad_sum} + {1'b0, rad_sum, 1'b0};
        mask_idx  = nps_pkg::IDX_W'(r_master.group) * nps_pkg::IDX_W'(GROUP_COUNT)
                    + nps_pkg::IDX_W'(partner.group);
        s1_grp_ok = ({1'b0, r_master.group} < 4'(GROUP_COUNT))
                    && ({1'b0, partner.group} < 4'(GROUP_COUNT))
                    && i_group_pair_mask[mask_idx];
    end

    always_comb begin
        s3_sum   = {2'b00, r_s3_sqx} + {2'b00, r_s3_sqy} + {2'b00, r_s3_sqz};
        s3_hit   = r_s3_v && r_s3_grp_ok
                   && (s3_sum <= nps_pkg::SUM_W'(r_s3_reach_sq));
        // A hit releases the hit held before it; the newest one waits for its last flag.
        emit_hit = adv && s3_hit && r_pend_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nps_pkg::ST_IDLE;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_s1_v <= issue;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
            end
            if (emit_flush) begin
                r_pend_v <= 1'b0;
            end else if (adv && s3_hit) begin
                r_pend_v <= 1'b1;
            end
            if (emit_hit || emit_flush) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_row   <= i_job.index;
            r_final <= i_job.final_j;
        end
        if (r_state == nps_pkg::ST_MLATCH) begin
            r_master <= partner;
            r_j      <= r_row + 1'b1;
        end else if (issue) begin
            r_j <= r_j + 1'b1;
        end
        if (adv) begin
            r_s1_j   <= r_j;
            r_s1_fin <= (r_j == r_final);

            r_s2_j      <= r_s1_j;
            r_s2_fin    <= r_s1_fin;
            r_s2_dx     <= s1_dx;
            r_s2_dy     <= s1_dy;
            r_s2_dz     <= s1_dz;
            r_s2_reach  <= s1_reach;
            r_s2_grp_ok <= s1_grp_ok;

            r_s3_j        <= r_s2_j;
            r_s3_fin      <= r_s2_fin;
            r_s3_sqx      <= r_s2_dx * r_s2_dx;
            r_s3_sqy      <= r_s2_dy * r_s2_dy;
            r_s3_sqz      <= r_s2_dz * r_s2_dz;
            r_s3_reach_sq <= r_s2_reach * r_s2_reach;
            r_s3_grp_ok   <= r_s2_grp_ok;
        end
        if (adv && s3_hit) begin
            r_pend_j <= r_s3_j;
        end
        if (emit_flush) begin
            r_out_master  <= r_row;
            r_out_partner <= r_pend_v ? r_pend_j : '0;
            r_out_found   <= r_pend_v;
            r_out_last    <= 1'b1;
        end else if (emit_hit) begin
            r_out_master  <= r_row;
            r_out_partner <= r_pend_j;
            r_out_found   <= 1'b1;
            r_out_last    <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_master_index  = r_out_master;
    assign o_partner_index = r_out_partner;
    assign o_found         = r_out_found;
    assign o_last          = r_out_last;

endmodule

/* sv/near_pair_search_top.sv */
// Near pair search: configuration registers, front end, job queue and back end.
// A load item is written into the store in the same cycle that the idle back end takes it
// from the queue; a row with no partners goes to the flush state and gives its item when
// the result register can take it. A scan of row i holds the back end and sends its
// P = count - 1 - i partners, one per cycle unless stalled, through three distance stages.
// Reset clears control state, the queue and both registers; the store is left as is.
module near_pair_search_top #(
    parameter int MAX_OBJECTS = nps_pkg::MAX_OBJECTS_DEF,
    parameter int GROUP_COUNT = nps_pkg::GROUP_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [nps_pkg::IDX_W-1:0]         i_index,
    input  logic signed [nps_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [nps_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [nps_pkg::POS_W-1:0]  i_pos_z,
    input  logic [nps_pkg::RAD_W-1:0]         i_radius,
    input  logic [nps_pkg::GRP_W-1:0]         i_group,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [nps_pkg::IDX_W-1:0]         o_master_index,
    output logic [nps_pkg::IDX_W-1:0]         o_partner_index,
    output logic                              o_found,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [nps_pkg::CNT_W-1:0]  r_object_count;
    logic [nps_pkg::MASK_W-1:0] r_group_pair_mask;

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    nps_pkg::t_job front_job;
    nps_pkg::t_job head_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_object_count    <= '0;
            r_group_pair_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nps_pkg::CFG_OBJECT_COUNT: r_object_count <= i_cfg_data[nps_pkg::CNT_W-1:0];
                nps_pkg::CFG_GROUP_MASK:   r_group_pair_mask <= i_cfg_data[nps_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    nps_front #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_index        (i_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_radius       (i_radius),
        .i_group        (i_group),
        .i_object_count (r_object_count),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_job          (front_job)
    );

    nps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    nps_back #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .GROUP_COUNT (GROUP_COUNT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_job             (head_job),
        .o_pop             (q_pop),
        .i_group_pair_mask (r_group_pair_mask),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_master_index    (o_master_index),
        .o_partner_index   (o_partner_index),
        .o_found           (o_found),
        .o_last            (o_last)
    );

endmodule

/* sv/nps_checker.sv */
// Port-level checks on the result channel, bound to the top level.
module nps_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [nps_pkg::IDX_W-1:0] o_master_index,
    input logic [nps_pkg::IDX_W-1:0] o_partner_index,
    input logic                      o_found,
    input logic                      o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_master_index)
            && $stable(o_partner_index) && $stable(o_found) && $stable(o_last))
        else $error("result item changed while stalled");

    a_empty_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last && (o_partner_index == '0))
        else $error("empty-row item is not a lone final item");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_partner_index > o_master_index)
        else $error("partner index not above master index");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind near_pair_search_top nps_checker u_nps_checker (.*);
